@@ rtl/hht_pkg.sv @@
`default_nettype none
package hht_pkg;

   localparam int HOME_BUCKETS     = 1024;
   localparam int OVERFLOW_BUCKETS = 256;
   localparam int HOP_SPAN         = 32;
   localparam int PROBE_SPAN       = 256;
   localparam int TABLE_SLOTS      = HOME_BUCKETS + OVERFLOW_BUCKETS;

   localparam int ADDR_W   = $clog2(TABLE_SLOTS);
   localparam int SUM_W    = ADDR_W + 1;
   localparam int HOME_W   = $clog2(HOME_BUCKETS);
   localparam int HOP_IW   = $clog2(HOP_SPAN);
   localparam int DIST_W   = $clog2(PROBE_SPAN + 1);
   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_BITS    = OP_W + KEY_W + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = STATUS_W + DATA_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_RSVD     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_NOROOM   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LK_BITS,
      S_LK_SEL,
      S_LK_CHK,
      S_PR_RD,
      S_PR_CHK,
      S_MV_TEST,
      S_BC_RD,
      S_BC_CHK,
      S_BC_MOVE,
      S_BC_CLR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } slot_word_type;

   localparam int SLOT_W = $bits(slot_word_type);

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [HOP_SPAN-1:0] wdata;
   } hop_req_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      slot_word_type     wdata;
   } slot_req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] data;
   } rsp_type;

   localparam logic [HOP_SPAN-1:0] HOP_ONE = {{(HOP_SPAN-1){1'b0}}, 1'b1};

   function automatic logic [HOP_IW-1:0] lowest_set(input logic [HOP_SPAN-1:0] v);
      logic [HOP_IW-1:0] r;
      r = '0;
      for (int i = HOP_SPAN - 1; i >= 0; i--) begin
         if (v[i]) r = HOP_IW'(i);
      end
      return r;
   endfunction

   function automatic logic [HOP_SPAN-1:0] low_mask(input logic [HOP_IW-1:0] n);
      logic [HOP_SPAN-1:0] m;
      m = '0;
      for (int i = 0; i < HOP_SPAN; i++) begin
         if (i < int'(n)) m[i] = 1'b1;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

@@ rtl/hopscotch_hash_table_core.sv @@
// Hopscotch hash table of 32-bit keys with 32-bit data.
// Request channel req_*: one word per operation (add, remove, contains).
// Response channel rsp_*: exactly one word per request, in request order,
// carrying status and, for a successful remove, the removed data.
// One request is worked on at a time. Every step is one access to the
// bucket memories (hop bitmaps, slots), which have a registered read.
// Add: the lookup as for contains, then a probe for a free bucket (up to 256
// buckets), then displacements that each scan hop bitmaps and move one entry.
// After reset the block sweeps all 1280 buckets of both memories, one bucket
// per cycle, with req_tready low.
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls, the following response holds in the
// engine and req_tready stays low until the register frees.
`default_nettype none
module hopscotch_hash_table_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // op [1:0], key [33:2], data_in [65:34], zero pad
   input  wire logic [hht_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // status [1:0], data_out [33:2], zero pad
   output logic      [hht_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   hht_pkg::hop_req_type         hop_req;
   hht_pkg::slot_req_type        slot_req;
   logic [hht_pkg::HOP_SPAN-1:0] hop_rdata;
   hht_pkg::slot_word_type       slot_rdata;
   logic [hht_pkg::SLOT_W-1:0]   slot_rraw;
   hht_pkg::rsp_type             rsp;
   logic                         done;
   logic                         rsp_busy;
   logic                         rsp_valid_ff, rsp_valid_in;
   hht_pkg::rsp_type             rsp_ff, rsp_in;

   assign slot_rdata = hht_pkg::slot_word_type'(slot_rraw);
   assign rsp_busy   = rsp_valid_ff && !rsp_tready;

   hht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (hht_pkg::op_type'(req_tdata[1:0])),
      .req_key    (req_tdata[33:2]),
      .req_data   (req_tdata[65:34]),
      .rsp_busy   (rsp_busy),
      .done       (done),
      .rsp        (rsp),
      .hop_req    (hop_req),
      .hop_rdata  (hop_rdata),
      .slot_req   (slot_req),
      .slot_rdata (slot_rdata)
   );

   hht_ram #(.WIDTH(hht_pkg::HOP_SPAN), .DEPTH(hht_pkg::TABLE_SLOTS)) u_hop_ram (
      .clock (clock),
      .we    (hop_req.we),
      .addr  (hop_req.addr),
      .wdata (hop_req.wdata),
      .rdata (hop_rdata)
   );

   hht_ram #(.WIDTH(hht_pkg::SLOT_W), .DEPTH(hht_pkg::TABLE_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_req.we),
      .addr  (slot_req.addr),
      .wdata (slot_req.wdata),
      .rdata (slot_rraw)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(hht_pkg::RSP_TDATA_W - hht_pkg::RSP_BITS){1'b0}},
                        rsp_ff.data, rsp_ff.status};

endmodule
`default_nettype wire

@@ rtl/hht_ram.sv @@
`default_nettype none
module hht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

@@ rtl/hht_ctrl.sv @@
`default_nettype none
module hht_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire hht_pkg::op_type               req_op,
   input  wire logic [hht_pkg::KEY_W-1:0]     req_key,
   input  wire logic [hht_pkg::DATA_W-1:0]    req_data,
   input  wire logic                          rsp_busy,
   output logic                               done,
   output hht_pkg::rsp_type                   rsp,
   output hht_pkg::hop_req_type               hop_req,
   input  wire logic [hht_pkg::HOP_SPAN-1:0]  hop_rdata,
   output hht_pkg::slot_req_type              slot_req,
   input  wire hht_pkg::slot_word_type        slot_rdata
);

   hht_pkg::state_type state_ff, state_in;
   hht_pkg::op_type    op_ff, op_in;
   logic [hht_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [hht_pkg::DATA_W-1:0]   data_ff, data_in;
   logic [hht_pkg::HOP_SPAN-1:0] mask_ff, mask_in;
   logic [hht_pkg::HOP_SPAN-1:0] bits_ff, bits_in;
   logic [hht_pkg::HOP_SPAN-1:0] bcbits_ff, bcbits_in;
   logic [hht_pkg::ADDR_W-1:0]   idx_ff, idx_in;
   logic [hht_pkg::ADDR_W-1:0]   free_ff, free_in;
   logic [hht_pkg::ADDR_W-1:0]   base_ff, base_in;
   logic [hht_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   logic [hht_pkg::HOP_IW-1:0]   hi_ff, hi_in;
   logic [hht_pkg::HOP_IW-1:0]   fd_ff, fd_in;
   logic [hht_pkg::HOP_IW-1:0]   bci_ff, bci_in;
   logic [hht_pkg::DIST_W-1:0]   dist_ff, dist_in;
   hht_pkg::status_type          status_ff, status_in;
   logic [hht_pkg::DATA_W-1:0]   dout_ff, dout_in;

   logic [hht_pkg::ADDR_W-1:0]   home;
   logic [hht_pkg::HOP_IW-1:0]   lk_pick;
   logic [hht_pkg::SUM_W-1:0]    lk_s;
   logic                         lk_hit;
   logic [hht_pkg::SUM_W-1:0]    pr_s;
   logic [hht_pkg::HOP_SPAN-1:0] bc_m;
   logic [hht_pkg::HOP_IW-1:0]   bc_pick;
   logic                         accept;

   assign home    = hht_pkg::ADDR_W'(key_ff[hht_pkg::HOME_W-1:0]);
   assign lk_pick = hht_pkg::lowest_set(mask_ff);
   assign lk_s    = hht_pkg::SUM_W'(home) + hht_pkg::SUM_W'(lk_pick);
   assign lk_hit  = slot_rdata.valid && (slot_rdata.key == key_ff);
   assign pr_s    = hht_pkg::SUM_W'(home) + hht_pkg::SUM_W'(dist_ff);
   assign bc_m    = hop_rdata & hht_pkg::low_mask(fd_ff);
   assign bc_pick = hht_pkg::lowest_set(bc_m);
   assign accept  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hht_pkg::S_CLEAR: begin
            if (clr_ff == hht_pkg::ADDR_W'(hht_pkg::TABLE_SLOTS - 1)) state_in = hht_pkg::S_IDLE;
         end
         hht_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == hht_pkg::OP_RSVD) ? hht_pkg::S_RESP : hht_pkg::S_LK_BITS;
            end
         end
         hht_pkg::S_LK_BITS: state_in = hht_pkg::S_LK_SEL;
         hht_pkg::S_LK_SEL: begin
            if (mask_ff == '0) begin
               state_in = (op_ff == hht_pkg::OP_ADD) ? hht_pkg::S_PR_RD : hht_pkg::S_RESP;
            end else if (lk_s < hht_pkg::SUM_W'(hht_pkg::TABLE_SLOTS)) begin
               state_in = hht_pkg::S_LK_CHK;
            end
         end
         hht_pkg::S_LK_CHK: state_in = lk_hit ? hht_pkg::S_RESP : hht_pkg::S_LK_SEL;
         hht_pkg::S_PR_RD: begin
            if (dist_ff == hht_pkg::DIST_W'(hht_pkg::PROBE_SPAN) ||
                pr_s >= hht_pkg::SUM_W'(hht_pkg::TABLE_SLOTS)) begin
               state_in = hht_pkg::S_RESP;
            end else begin
               state_in = hht_pkg::S_PR_CHK;
            end
         end
         hht_pkg::S_PR_CHK: begin
            state_in = slot_rdata.valid ? hht_pkg::S_PR_RD : hht_pkg::S_MV_TEST;
         end
         hht_pkg::S_MV_TEST: begin
            state_in = (dist_ff < hht_pkg::DIST_W'(hht_pkg::HOP_SPAN)) ?
                       hht_pkg::S_RESP : hht_pkg::S_BC_RD;
         end
         hht_pkg::S_BC_RD: state_in = (fd_ff == '0) ? hht_pkg::S_RESP : hht_pkg::S_BC_CHK;
         hht_pkg::S_BC_CHK: state_in = (bc_m == '0) ? hht_pkg::S_BC_RD : hht_pkg::S_BC_MOVE;
         hht_pkg::S_BC_MOVE: state_in = hht_pkg::S_BC_CLR;
         hht_pkg::S_BC_CLR: state_in = hht_pkg::S_MV_TEST;
         hht_pkg::S_RESP: begin
            if (!rsp_busy) state_in = hht_pkg::S_IDLE;
         end
         default: state_in = hht_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      data_in   = data_ff;
      mask_in   = mask_ff;
      bits_in   = bits_ff;
      bcbits_in = bcbits_ff;
      idx_in    = idx_ff;
      free_in   = free_ff;
      base_in   = base_ff;
      clr_in    = clr_ff;
      hi_in     = hi_ff;
      fd_in     = fd_ff;
      bci_in    = bci_ff;
      dist_in   = dist_ff;
      status_in = status_ff;
      dout_in   = dout_ff;
      hop_req   = '0;
      slot_req  = '0;
      req_ready = (state_ff == hht_pkg::S_IDLE);
      done      = (state_ff == hht_pkg::S_RESP) && !rsp_busy;
      rsp.status = status_ff;
      rsp.data   = dout_ff;

      unique case (state_ff)
         hht_pkg::S_CLEAR: begin
            hop_req.we    = 1'b1;
            hop_req.addr  = clr_ff;
            slot_req.we   = 1'b1;
            slot_req.addr = clr_ff;
            clr_in        = clr_ff + 1'b1;
         end
         hht_pkg::S_IDLE: begin
            hop_req.addr = hht_pkg::ADDR_W'(req_key[hht_pkg::HOME_W-1:0]);
            if (accept) begin
               op_in     = req_op;
               key_in    = req_key;
               data_in   = req_data;
               status_in = hht_pkg::ST_NOTFOUND;
               dout_in   = '0;
            end
         end
         hht_pkg::S_LK_BITS: begin
            mask_in = hop_rdata;
            bits_in = hop_rdata;
         end
         hht_pkg::S_LK_SEL: begin
            if (mask_ff != '0) begin
               mask_in = mask_ff & ~(hht_pkg::HOP_ONE << lk_pick);
               slot_req.addr = lk_s[hht_pkg::ADDR_W-1:0];
               idx_in  = lk_s[hht_pkg::ADDR_W-1:0];
               hi_in   = lk_pick;
            end else if (op_ff == hht_pkg::OP_ADD) begin
               dist_in = '0;
            end
         end
         hht_pkg::S_LK_CHK: begin
            if (lk_hit) begin
               unique case (op_ff)
                  hht_pkg::OP_ADD: status_in = hht_pkg::ST_PRESENT;
                  hht_pkg::OP_REMOVE: begin
                     status_in      = hht_pkg::ST_OK;
                     dout_in        = slot_rdata.data;
                     slot_req.we    = 1'b1;
                     slot_req.addr  = idx_ff;
                     slot_req.wdata = '{valid: 1'b0, key: slot_rdata.key,
                                        data: slot_rdata.data};
                     hop_req.we     = 1'b1;
                     hop_req.addr   = home;
                     hop_req.wdata  = bits_ff & ~(hht_pkg::HOP_ONE << hi_ff);
                  end
                  default: status_in = hht_pkg::ST_OK;
               endcase
            end
         end
         hht_pkg::S_PR_RD: begin
            slot_req.addr = pr_s[hht_pkg::ADDR_W-1:0];
            if (dist_ff == hht_pkg::DIST_W'(hht_pkg::PROBE_SPAN) ||
                pr_s >= hht_pkg::SUM_W'(hht_pkg::TABLE_SLOTS)) begin
               status_in = hht_pkg::ST_NOROOM;
            end
         end
         hht_pkg::S_PR_CHK: begin
            if (slot_rdata.valid) begin
               dist_in = dist_ff + 1'b1;
            end else begin
               free_in = pr_s[hht_pkg::ADDR_W-1:0];
            end
         end
         hht_pkg::S_MV_TEST: begin
            if (dist_ff < hht_pkg::DIST_W'(hht_pkg::HOP_SPAN)) begin
               hop_req.we     = 1'b1;
               hop_req.addr   = home;
               hop_req.wdata  = bits_ff | (hht_pkg::HOP_ONE << dist_ff[hht_pkg::HOP_IW-1:0]);
               slot_req.we    = 1'b1;
               slot_req.addr  = free_ff;
               slot_req.wdata = '{valid: 1'b1, key: key_ff, data: data_ff};
               status_in      = hht_pkg::ST_OK;
            end else begin
               base_in = free_ff - hht_pkg::ADDR_W'(hht_pkg::HOP_SPAN - 1);
               fd_in   = hht_pkg::HOP_IW'(hht_pkg::HOP_SPAN - 1);
            end
         end
         hht_pkg::S_BC_RD: begin
            hop_req.addr = base_ff;
            if (fd_ff == '0) status_in = hht_pkg::ST_NOROOM;
         end
         hht_pkg::S_BC_CHK: begin
            if (bc_m == '0) begin
               base_in = base_ff + 1'b1;
               fd_in   = fd_ff - 1'b1;
            end else begin
               bcbits_in     = hop_rdata;
               bci_in        = bc_pick;
               idx_in        = base_ff + hht_pkg::ADDR_W'(bc_pick);
               slot_req.addr = base_ff + hht_pkg::ADDR_W'(bc_pick);
            end
         end
         hht_pkg::S_BC_MOVE: begin
            slot_req.we    = 1'b1;
            slot_req.addr  = free_ff;
            slot_req.wdata = '{valid: 1'b1, key: slot_rdata.key, data: slot_rdata.data};
            hop_req.we     = 1'b1;
            hop_req.addr   = base_ff;
            hop_req.wdata  = (bcbits_ff | (hht_pkg::HOP_ONE << fd_ff)) &
                             ~(hht_pkg::HOP_ONE << bci_ff);
         end
         hht_pkg::S_BC_CLR: begin
            slot_req.we    = 1'b1;
            slot_req.addr  = idx_ff;
            slot_req.wdata = '{valid: 1'b0, key: key_ff, data: data_ff};
            free_in        = idx_ff;
            dist_in        = dist_ff - hht_pkg::DIST_W'(fd_ff) + hht_pkg::DIST_W'(bci_ff);
         end
         hht_pkg::S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hht_pkg::S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      data_ff   <= data_in;
      mask_ff   <= mask_in;
      bits_ff   <= bits_in;
      bcbits_ff <= bcbits_in;
      idx_ff    <= idx_in;
      free_ff   <= free_in;
      base_ff   <= base_in;
      hi_ff     <= hi_in;
      fd_ff     <= fd_in;
      bci_ff    <= bci_in;
      dist_ff   <= dist_in;
      status_ff <= status_in;
      dout_ff   <= dout_in;
   end

endmodule
`default_nettype wire

@@ rtl/hht_checker.sv @@
`default_nettype none
module hht_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [hht_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [hht_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != hht_pkg::ST_OK |-> rsp_tdata[33:2] == '0)
      else $error("data_out nonzero on failed operation");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[hht_pkg::RSP_TDATA_W-1:hht_pkg::RSP_BITS] == '0)
      else $error("response pad bits set");

   a_clear_pass: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ready during clearing pass");

endmodule

bind hopscotch_hash_table_core hht_checker u_hht_checker (.*);
`default_nettype wire

@@ dv/tb_hopscotch_hash_table_core.sv @@
`timescale 1ns / 1ps
module tb_hopscotch_hash_table_core;
   import hht_pkg::*;

   typedef struct {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } table_req_type;

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] data;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   hopscotch_hash_table_core dut (.*);

   always #2 clock = ~clock;

   // shadow table
   bit                tbl_valid [TABLE_SLOTS];
   logic [KEY_W-1:0]  tbl_key   [TABLE_SLOTS];
   logic [DATA_W-1:0] tbl_data  [TABLE_SLOTS];
   bit [31:0]         tbl_hop   [TABLE_SLOTS];

   table_req_type pending_reqs[$];
   table_rsp_type expected_rsps[$];
   logic [KEY_W-1:0] live_keys[$];
   int error_count = 0;
   int rsp_count = 0;

   function automatic int find_slot(logic [KEY_W-1:0] k);
      int h;
      h = int'(k % HOME_BUCKETS);
      for (int i = 0; i < HOP_SPAN; i++)
         if (tbl_hop[h][i] && h + i < TABLE_SLOTS && tbl_valid[h+i] && tbl_key[h+i] == k)
            return h + i;
      return -1;
   endfunction

   function automatic bit move_free_closer(inout int free_slot, inout int hop_dist);
      int base;
      logic [31:0] bits;
      base = free_slot - (HOP_SPAN - 1);
      for (int fd = HOP_SPAN - 1; fd > 0; fd--, base++) begin
         bits = tbl_hop[base];
         for (int i = 0; i < fd; i++) begin
            if (bits[i]) begin
               tbl_key[free_slot] = tbl_key[base+i];
               tbl_data[free_slot] = tbl_data[base+i];
               tbl_valid[free_slot] = 1'b1;
               tbl_valid[base+i] = 1'b0;
               bits[fd] = 1'b1;
               bits[i] = 1'b0;
               tbl_hop[base] = bits;
               free_slot = base + i;
               hop_dist = hop_dist - fd + i;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic status_type table_insert(logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
      int h, hop_dist, free_slot;
      bit found;
      h = int'(k % HOME_BUCKETS);
      found = 1'b0;
      free_slot = 0;
      if (find_slot(k) >= 0) return ST_PRESENT;
      for (hop_dist = 0; hop_dist < PROBE_SPAN; hop_dist++) begin
         if (h + hop_dist >= TABLE_SLOTS) break;
         if (!tbl_valid[h+hop_dist]) begin
            free_slot = h + hop_dist;
            found = 1'b1;
            break;
         end
      end
      if (!found) return ST_NOROOM;
      while (hop_dist >= HOP_SPAN)
         if (!move_free_closer(free_slot, hop_dist)) return ST_NOROOM;
      tbl_hop[h][hop_dist] = 1'b1;
      tbl_key[free_slot] = k;
      tbl_data[free_slot] = d;
      tbl_valid[free_slot] = 1'b1;
      return ST_OK;
   endfunction

   function automatic table_rsp_type table_apply(table_req_type r);
      table_rsp_type o;
      int s, h;
      o.status = ST_NOTFOUND;
      o.data = '0;
      case (r.op)
         OP_ADD: begin
            o.status = table_insert(r.key, r.data);
         end
         OP_REMOVE: begin
            s = find_slot(r.key);
            if (s >= 0) begin
               h = int'(r.key % HOME_BUCKETS);
               o.data = tbl_data[s];
               tbl_valid[s] = 1'b0;
               tbl_hop[h][s-h] = 1'b0;
               o.status = ST_OK;
            end
         end
         OP_CONTAINS: begin
            if (find_slot(r.key) >= 0) o.status = ST_OK;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic queue_req(op_type op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
      table_req_type r;
      r.op = op;
      r.key = k;
      r.data = d;
      pending_reqs.push_back(r);
      if (op == OP_ADD) live_keys.push_back(k);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if (live_keys.size() > 0 && $urandom_range(0, 2) != 0)
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return {2'($urandom_range(0, 3)), 20'd0, 10'($urandom_range(0, 15))};
         2: return ($urandom() & 32'hffff_fc00) | (32'd1010 + $urandom_range(0, 13));
         default: return {8'($urandom_range(0, 255)), 14'd0, 10'($urandom_range(100, 103))};
      endcase
   endfunction

   // driver
   int send_gap = 0;
   bit req_tready_seen = 1'b0;
   always @(negedge clock) begin
      logic [REQ_TDATA_W-1:0] req_word;
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_word = '0;
               req_word[OP_W-1:0] = pending_reqs[0].op;
               req_word[OP_W+KEY_W-1:OP_W] = pending_reqs[0].key;
               req_word[OP_W+KEY_W+DATA_W-1:OP_W+KEY_W] = pending_reqs[0].data;
               req_tvalid <= 1'b1;
               req_tdata <= req_word;
               void'(pending_reqs.pop_front());
               send_gap <= int'($urandom_range(0, 4));
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // accept detection at rising edge, prediction
   always @(posedge clock) begin
      table_req_type r;
      req_tready_seen <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         r.op = op_type'(req_tdata[OP_W-1:0]);
         r.key = req_tdata[OP_W+KEY_W-1:OP_W];
         r.data = req_tdata[OP_W+KEY_W+DATA_W-1:OP_W+KEY_W];
         expected_rsps.push_back(table_apply(r));
      end
   end

   // monitor
   always @(posedge clock) begin
      table_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsps.size() == 0) begin
            report("unexpected word", rsp_tdata[31:0], '0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_tdata[STATUS_W-1:0] !== e.status)
               report("status", 32'(rsp_tdata[STATUS_W-1:0]), 32'(e.status));
            if (rsp_tdata[STATUS_W+DATA_W-1:STATUS_W] !== e.data)
               report("data_out", rsp_tdata[STATUS_W+DATA_W-1:STATUS_W], e.data);
         end
      end
   end

   // receiver stall
   int rcv_gap = 0;
   int hold_off = 0;
   bit held = 1'b0;
   always @(negedge clock) begin
      if (!held && rsp_count >= 150) begin
         held <= 1'b1;
         hold_off <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tready && !rsp_tvalid) begin
         rsp_tready <= 1'b1;
      end else if (rcv_gap > 0) begin
         rcv_gap <= rcv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rcv_gap <= (rsp_tready && rsp_tvalid) ? int'($urandom_range(0, 4)) : 0;
      end
   end

   initial begin
      logic [KEY_W-1:0] k;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed
      queue_req(OP_CONTAINS, 32'h0, 32'h0);
      queue_req(OP_ADD, 32'h0, 32'hffff_ffff);
      queue_req(OP_ADD, 32'h0, 32'h1234_5678);
      queue_req(OP_ADD, 32'hffff_ffff, 32'h0);
      queue_req(OP_CONTAINS, 32'hffff_ffff, 32'h0);
      queue_req(OP_REMOVE, 32'hffff_ffff, 32'hdead_beef);
      queue_req(OP_REMOVE, 32'hffff_ffff, 32'h0);
      queue_req(OP_RSVD, 32'h0, 32'haaaa_5555);
      queue_req(OP_REMOVE, 32'h0, 32'h0);
      // fill one home bucket with twelve keys, all within its hop range
      for (int i = 0; i < 12; i++)
         queue_req(OP_ADD, {22'(i), 10'd1023}, 32'(i) ^ 32'h5555_aaaa);
      queue_req(OP_RSVD, 32'hffff_ffff, 32'hffff_ffff);
      // random
      for (int n = 0; n < 250; n++) begin
         k = pick_key();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: queue_req(OP_ADD, k, $urandom());
            5, 6: queue_req(OP_REMOVE, k, $urandom());
            7, 8: queue_req(OP_CONTAINS, k, $urandom());
            default: queue_req(OP_RSVD, k, $urandom());
         endcase
      end
      // dense cluster on the last home buckets: probe end and no room
      for (int i = 0; i < 280; i++)
         queue_req(OP_ADD, {22'($urandom()), 10'(1000 + (i % 24))}, $urandom());
      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_hopscotch_hash_table_core: clean");
      end else begin
         $display("tb_hopscotch_hash_table_core: errors");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_hopscotch_hash_table_core: errors");
      $finish;
   end

endmodule

@@ files.f @@
rtl/hht_pkg.sv
rtl/hht_ram.sv
rtl/hht_ctrl.sv
rtl/hopscotch_hash_table_core.sv
rtl/hht_checker.sv
dv/tb_hopscotch_hash_table_core.sv
